/* rtl/core/column_quad_rle_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Column quad RLE decoder - assertion macros
// Shared property wrappers for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef COLUMN_QUAD_RLE_DECODER_TOP_DEFINES_SVH
`define COLUMN_QUAD_RLE_DECODER_TOP_DEFINES_SVH

// Property checked on every clock edge, ignored while reset is high.
`define CQRD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CQRD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cqrd_pkg.sv */
// ----------------------------------------------------------------------------
// cqrd_pkg
// Types and constants shared by the column quad RLE decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cqrd_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_B0  = 3'd0;
  localparam logic [2:0] PH_B1  = 3'd1;
  localparam logic [2:0] PH_B2  = 3'd2;
  localparam logic [2:0] PH_B3  = 3'd3;
  localparam logic [2:0] PH_CNT = 3'd4;
  localparam logic [2:0] PH_EXT = 3'd5;

  // Register indexes (paddr[2]).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [9:0] WIDTH_RESET  = 10'd240;
  localparam logic [9:0] HEIGHT_RESET = 10'd160;

  // Pixel step between columns.
  localparam logic [9:0] QUAD_PIXELS = 10'd4;

  // Effective frame geometry.
  typedef struct packed {
    logic [9:0] width;
    logic [9:0] height;
  } geom_t;

  // One run descriptor between the parser and the address stage.
  typedef struct packed {
    logic [31:0] quad;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [8:0]  count;
    logic        is_repeat;
    logic        column_done;
    logic        frame_done;
    logic        overrun;
  } run_desc_t;

endpackage

`default_nettype wire

/* rtl/core/cqrd_in_if.sv */
// ----------------------------------------------------------------------------
// cqrd_in_if
// Byte stream channel into the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_in_frame;

  modport source (output valid, output byte_value, output last_in_frame, input ready);
  modport sink   (input valid, input byte_value, input last_in_frame, output ready);
endinterface

`default_nettype wire

/* rtl/core/cqrd_out_if.sv */
// ----------------------------------------------------------------------------
// cqrd_out_if
// Run descriptor channel out of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqrd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] quad_value;
  logic [17:0] start_address;
  logic [8:0]  start_row;
  logic [8:0]  start_column;
  logic [8:0]  row_count;
  logic        is_repeat;
  logic        column_done;
  logic        frame_done;
  logic        overrun;

  modport source (
    output valid, output quad_value, output start_address, output start_row,
    output start_column, output row_count, output is_repeat, output column_done,
    output frame_done, output overrun, input ready
  );
  modport sink (
    input valid, input quad_value, input start_address, input start_row,
    input start_column, input row_count, input is_repeat, input column_done,
    input frame_done, input overrun, output ready
  );
endinterface

`default_nettype wire

/* rtl/core/cqrd_fifo.sv */
// ----------------------------------------------------------------------------
// cqrd_fifo
// Two-entry descriptor queue between the parser and the address stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cqrd_fifo (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  cqrd_pkg::run_desc_t  push_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 empty,
  output cqrd_pkg::run_desc_t  head
);

  cqrd_pkg::run_desc_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cqrd_front.sv */
// ----------------------------------------------------------------------------
// cqrd_front
// Byte parser and column/row tracker; builds one run descriptor per literal or run.
// ----------------------------------------------------------------------------
`default_nettype none

module cqrd_front #(
  parameter int COL_W = 10,
  parameter int ROW_W = 10
) (
  input  wire                  clk,
  input  wire                  rst,
  cqrd_in_if.sink              byte_in,
  input  cqrd_pkg::geom_t      geom,
  input  wire                  fifo_full,
  output logic                 push,
  output cqrd_pkg::run_desc_t  push_data
);

  logic [31:0]      cur_quad, cur_quad_next;
  logic [31:0]      prev_quad, prev_quad_next;
  logic [2:0]       phase, phase_next;
  logic             rep_ok, rep_ok_next;
  logic [COL_W-1:0] col_pos, col_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;

  logic        accept;
  logic [31:0] quad_new;
  logic        go;
  logic [8:0]  cnt;
  logic        rep;
  logic [9:0]  col_a, row_a, col_b, row_b, col_c;
  logic [10:0] sum;
  logic        ovr;
  logic        emit;
  logic [7:0]  b;

  assign byte_in.ready = ~fifo_full;
  assign accept        = byte_in.valid & byte_in.ready;
  assign b             = byte_in.byte_value;

  always_comb begin
    quad_new = cur_quad;
    case (phase)
      cqrd_pkg::PH_B0: quad_new[7:0]   = b;
      cqrd_pkg::PH_B1: quad_new[15:8]  = b;
      cqrd_pkg::PH_B2: quad_new[23:16] = b;
      cqrd_pkg::PH_B3: quad_new[31:24] = b;
      default:         quad_new        = cur_quad;
    endcase
  end

  always_comb begin
    cur_quad_next  = cur_quad;
    prev_quad_next = prev_quad;
    phase_next     = phase;
    rep_ok_next    = rep_ok;
    go             = 1'b0;
    cnt            = 9'd1;
    rep            = 1'b0;

    case (phase)
      cqrd_pkg::PH_B0: begin
        cur_quad_next = quad_new;
        phase_next    = cqrd_pkg::PH_B1;
      end
      cqrd_pkg::PH_B1: begin
        cur_quad_next = quad_new;
        phase_next    = cqrd_pkg::PH_B2;
      end
      cqrd_pkg::PH_B2: begin
        cur_quad_next = quad_new;
        phase_next    = cqrd_pkg::PH_B3;
      end
      cqrd_pkg::PH_B3: begin
        cur_quad_next = quad_new;
        if (rep_ok && (quad_new == prev_quad)) begin
          phase_next = cqrd_pkg::PH_CNT;
        end else begin
          phase_next     = cqrd_pkg::PH_B0;
          prev_quad_next = quad_new;
          rep_ok_next    = 1'b1;
          go             = 1'b1;
        end
      end
      cqrd_pkg::PH_CNT: begin
        if (b != 8'd0) begin
          phase_next  = cqrd_pkg::PH_B0;
          rep_ok_next = 1'b0;
          go          = 1'b1;
          cnt         = {1'b0, b};
          rep         = 1'b1;
        end else begin
          phase_next = cqrd_pkg::PH_EXT;
        end
      end
      default: begin
        // extended count: 256 plus this byte
        phase_next  = cqrd_pkg::PH_B0;
        rep_ok_next = 1'b0;
        go          = 1'b1;
        cnt         = {1'b1, b};
        rep         = 1'b1;
      end
    endcase

    // run placement
    col_a        = 10'(col_pos);
    row_a        = 10'(row_pos);
    col_b        = col_a;
    row_b        = row_a;
    col_c        = col_a;
    sum          = 11'd0;
    ovr          = 1'b0;
    emit         = 1'b0;
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    push_data    = '0;
    push_data.quad = cur_quad_next;

    if (go && (col_a < geom.width)) begin
      if (row_a >= geom.height) begin
        col_b       = col_a + cqrd_pkg::QUAD_PIXELS;
        row_b       = 10'd0;
        rep_ok_next = 1'b0;
      end
      col_pos_next = COL_W'(col_b);
      row_pos_next = ROW_W'(row_b);
      if (col_b < geom.width) begin
        emit = 1'b1;
        sum  = {1'b0, row_b} + {2'b00, cnt};
        ovr  = sum > {1'b0, geom.height};
        push_data.row       = row_b;
        push_data.col       = col_b;
        push_data.count     = ovr ? 9'(geom.height - row_b) : cnt;
        push_data.is_repeat = rep;
        push_data.overrun   = ovr;
        if (sum >= {1'b0, geom.height}) begin
          col_c                 = col_b + cqrd_pkg::QUAD_PIXELS;
          col_pos_next          = COL_W'(col_c);
          row_pos_next          = '0;
          rep_ok_next           = 1'b0;
          push_data.column_done = 1'b1;
          push_data.frame_done  = (col_c >= geom.width);
        end else begin
          row_pos_next = ROW_W'(sum);
        end
      end
    end

    // drop all frame state after the last byte
    if (byte_in.last_in_frame) begin
      cur_quad_next  = '0;
      prev_quad_next = '0;
      phase_next     = cqrd_pkg::PH_B0;
      rep_ok_next    = 1'b0;
      col_pos_next   = '0;
      row_pos_next   = '0;
    end
  end

  assign push = accept & emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_quad  <= '0;
      prev_quad <= '0;
      phase     <= cqrd_pkg::PH_B0;
      rep_ok    <= 1'b0;
      col_pos   <= '0;
      row_pos   <= '0;
    end else if (accept) begin
      cur_quad  <= cur_quad_next;
      prev_quad <= prev_quad_next;
      phase     <= phase_next;
      rep_ok    <= rep_ok_next;
      col_pos   <= col_pos_next;
      row_pos   <= row_pos_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cqrd_back.sv */
// ----------------------------------------------------------------------------
// cqrd_back
// Address stage and output register for run descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module cqrd_back (
  input  wire                  clk,
  input  wire                  rst,
  input  cqrd_pkg::geom_t      geom,
  input  wire                  empty,
  input  cqrd_pkg::run_desc_t  head,
  output logic                 pop,
  cqrd_out_if.source           run_out
);

  logic        out_valid;
  logic [31:0] quad_q;
  logic [17:0] addr_q;
  logic [8:0]  row_q;
  logic [8:0]  col_q;
  logic [8:0]  count_q;
  logic        rep_q;
  logic        cd_q;
  logic        fd_q;
  logic        ovr_q;
  logic [19:0] prod;
  logic [19:0] addr_full;

  assign pop       = ~empty & (~out_valid | run_out.ready);
  assign prod      = head.row * geom.width;
  assign addr_full = prod + {10'd0, head.col};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (run_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      quad_q  <= head.quad;
      addr_q  <= addr_full[17:0];
      row_q   <= head.row[8:0];
      col_q   <= head.col[8:0];
      count_q <= head.count;
      rep_q   <= head.is_repeat;
      cd_q    <= head.column_done;
      fd_q    <= head.frame_done;
      ovr_q   <= head.overrun;
    end
  end

  assign run_out.valid         = out_valid;
  assign run_out.quad_value    = quad_q;
  assign run_out.start_address = addr_q;
  assign run_out.start_row     = row_q;
  assign run_out.start_column  = col_q;
  assign run_out.row_count     = count_q;
  assign run_out.is_repeat     = rep_q;
  assign run_out.column_done   = cd_q;
  assign run_out.frame_done    = fd_q;
  assign run_out.overrun       = ovr_q;

endmodule

`default_nettype wire

/* rtl/core/column_quad_rle_decoder_top.sv */
// ----------------------------------------------------------------------------
// column_quad_rle_decoder_top
// Column quad RLE decoder: bytes in, one run descriptor per literal or run out.
// ----------------------------------------------------------------------------
//
//   channel   dir   width  what moves
//   --------  ----  -----  ----------------------------------------------
//   byte_in   in    9      one compressed byte plus end-of-frame mark
//   run_out   out   81     quad, start address/row/column, row count, flags
//   APB       in    32     frame_width at 0x0, frame_height at 0x4
//
// Rate: one byte per cycle while the queue has room. A run is written to the
// queue as the byte that closes it is taken, then registered by the address stage.
// Reset: rst is synchronous, active high; registers return to 240 x 160.
// Stalls: a two-entry queue parts parser and address stage; byte_in.ready
// drops only while that queue is full, which happens after run_out stalls.
//
`default_nettype none

module column_quad_rle_decoder_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire         clk,
  input  wire         rst,
  cqrd_in_if.sink     byte_in,
  cqrd_out_if.source  run_out,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Width limit rounded down to whole quads.
  localparam int WLIM  = (MAX_WIDTH / 4) * 4;
  localparam int HLIM  = MAX_HEIGHT;
  // Column position runs up to the effective width (at most 1020 pixels).
  localparam int COL_W = (WLIM >= 1020) ? 10 : $clog2(WLIM + 1);
  // Row position stays below the effective height (at most 1023 rows).
  localparam int ROW_W = (HLIM >= 1024) ? 10 : ((HLIM < 2) ? 1 : $clog2(HLIM));

  logic [9:0]          width_reg;
  logic [9:0]          height_reg;
  logic [9:0]          width_round;
  logic [9:0]          height_min;
  cqrd_pkg::geom_t     geom;
  logic                cfg_write;

  logic                fifo_push;
  cqrd_pkg::run_desc_t fifo_in;
  logic                fifo_full;
  logic                fifo_pop;
  logic                fifo_empty;
  cqrd_pkg::run_desc_t fifo_head;

  // Configuration port: write on the access cycle, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= cqrd_pkg::WIDTH_RESET;
      height_reg <= cqrd_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        cqrd_pkg::REG_WIDTH:  width_reg  <= pwdata[9:0];
        cqrd_pkg::REG_HEIGHT: height_reg <= pwdata[9:0];
        default:              width_reg  <= width_reg;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      cqrd_pkg::REG_WIDTH:  prdata = {22'd0, width_reg};
      cqrd_pkg::REG_HEIGHT: prdata = {22'd0, height_reg};
      default:              prdata = 32'd0;
    endcase
  end

  // Effective geometry: round width down to whole quads and clamp it,
  // treat a height of zero as one row and clamp it.
  assign width_round = {width_reg[9:2], 2'b00};
  assign height_min  = (height_reg == 10'd0) ? 10'd1 : height_reg;

  always_comb begin
    geom.width  = (int'(width_round) > WLIM) ? 10'(WLIM) : width_round;
    geom.height = (int'(height_min) > HLIM) ? 10'(HLIM) : height_min;
  end

  // Parser: classify each byte and place the run in the frame.
  cqrd_front #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .geom      (geom),
    .fifo_full (fifo_full),
    .push      (fifo_push),
    .push_data (fifo_in)
  );

  // Queue: absorb output stalls so the parser keeps taking bytes.
  cqrd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (fifo_in),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .empty     (fifo_empty),
    .head      (fifo_head)
  );

  // Address stage: compute row*width+column and hold the result.
  cqrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .empty   (fifo_empty),
    .head    (fifo_head),
    .pop     (fifo_pop),
    .run_out (run_out)
  );

endmodule

`default_nettype wire

/* rtl/core/cqrd_checker.sv */
// ----------------------------------------------------------------------------
// cqrd_checker
// Port-level checks on the decoder's run descriptor output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "column_quad_rle_decoder_top_defines.svh"

module cqrd_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_quad,
  input wire [8:0]  out_count,
  input wire        out_repeat,
  input wire        out_cd,
  input wire        out_fd,
  input wire        out_ovr
);

  `CQRD_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "output valid after reset")
  `CQRD_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_quad), "stalled run changed")
  `CQRD_ASSERT(a_count_nonzero, clk, rst, out_valid |-> out_count != 9'd0, "empty run")
  `CQRD_ASSERT(a_frame_ends_column, clk, rst, out_valid && out_fd |-> out_cd, "frame done without column done")
  `CQRD_ASSERT(a_overrun_is_repeat, clk, rst, out_valid && out_ovr |-> out_cd && out_repeat, "bad overrun")

endmodule

bind column_quad_rle_decoder_top cqrd_checker u_cqrd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (run_out.valid),
  .out_ready  (run_out.ready),
  .out_quad   (run_out.quad_value),
  .out_count  (run_out.row_count),
  .out_repeat (run_out.is_repeat),
  .out_cd     (run_out.column_done),
  .out_fd     (run_out.frame_done),
  .out_ovr    (run_out.overrun)
);

`default_nettype wire

/* tb/tb_column_quad_rle_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_quad_rle_decoder_top
// Self-checking bench for the column quad RLE decoder. Feeds compressed
// frames byte by byte, mirrors the parser and column walk in a local
// predictor, and checks every run descriptor field by field, in order.
// ----------------------------------------------------------------------------

module tb_column_quad_rle_decoder_top;

  localparam int MAX_W          = 512;
  localparam int MAX_H          = 512;
  localparam int EXT_COUNT_BASE = 256;
  localparam int PHASES         = 12;
  localparam int RANDOM_BYTES   = 1600;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 200000;

  // One byte request on the input channel.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  // One run descriptor as it leaves the decoder.
  typedef struct packed {
    logic [31:0] quad;
    logic [17:0] addr;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [8:0]  rows;
    logic        rep;
    logic        col_done;
    logic        frm_done;
    logic        ovr;
  } run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cqrd_in_if  byte_in ();
  cqrd_out_if run_out ();

  column_quad_rle_decoder_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .run_out (run_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 20 ns period: high half, then low half.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  stream_byte_t byte_backlog[$];   // byte requests not yet offered
  run_t         runs_due[$];       // descriptors predicted, not yet seen
  int           bytes_queued;
  int           mismatches;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  // Predictor copy of the registers and the decoder state.
  logic [9:0]  reg_width;
  logic [9:0]  reg_height;
  logic [31:0] cur_quad;
  logic [31:0] prev_quad;
  logic [2:0]  phase;
  logic        rep_ok;
  int unsigned col_pos;
  int unsigned row_pos;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Width rounds down to whole quads and saturates at the build limit.
  function automatic int unsigned active_width();
    int unsigned w;
    w = reg_width & 10'h3FC;
    if (w > (MAX_W / 4) * 4) w = (MAX_W / 4) * 4;
    return w;
  endfunction

  // Height 0 behaves as a single row; above the build limit it saturates.
  function automatic int unsigned active_height();
    int unsigned h;
    h = reg_height;
    if (h == 0) h = 1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  function automatic void clear_decoder();
    cur_quad  = '0;
    prev_quad = '0;
    phase     = cqrd_pkg::PH_B0;
    rep_ok    = 1'b0;
    col_pos   = 0;
    row_pos   = 0;
  endfunction

  // Place one literal or run in the current column. Returns 0 when the frame
  // is already full and nothing goes out.
  function automatic bit place_run(input logic [31:0] quad, input int unsigned count,
                                   input logic rep, output run_t r);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = active_width();
    h = active_height();
    r = '0;
    if (col_pos >= w) return 1'b0;
    // A smaller height written mid-frame can leave the row past the bottom:
    // step to the next column before placing anything.
    if (row_pos >= h) begin
      col_pos += cqrd_pkg::QUAD_PIXELS;
      row_pos = 0;
      rep_ok  = 1'b0;
      if (col_pos >= w) return 1'b0;
    end
    n = count;
    if (n > h - row_pos) begin
      n     = h - row_pos;
      r.ovr = 1'b1;
    end
    r.quad = quad;
    r.addr = 18'(row_pos * w + col_pos);
    r.row  = 9'(row_pos);
    r.col  = 9'(col_pos);
    r.rows = 9'(n);
    r.rep  = rep;
    row_pos += n;
    if (row_pos >= h) begin
      r.col_done = 1'b1;
      col_pos   += cqrd_pkg::QUAD_PIXELS;
      rep_ok     = 1'b0;
      row_pos    = 0;
      r.frm_done = (col_pos >= w);
    end
    return 1'b1;
  endfunction

  // Advance the parser by one accepted byte and queue any descriptor it closes.
  task automatic decode_byte(input logic [7:0] value, input logic last);
    run_t r;
    bit   got;
    got = 1'b0;
    if (phase <= cqrd_pkg::PH_B3) begin
      cur_quad[8 * phase +: 8] = value;
      if (phase != cqrd_pkg::PH_B3) begin
        phase = phase + 3'd1;
      end else if (rep_ok && cur_quad == prev_quad) begin
        phase = cqrd_pkg::PH_CNT;
      end else begin
        phase     = cqrd_pkg::PH_B0;
        prev_quad = cur_quad;
        rep_ok    = 1'b1;
        got       = place_run(cur_quad, 1, 1'b0, r);
      end
    end else if (phase == cqrd_pkg::PH_CNT && value != 8'd0) begin
      phase  = cqrd_pkg::PH_B0;
      rep_ok = 1'b0;
      got    = place_run(cur_quad, value, 1'b1, r);
    end else if (phase == cqrd_pkg::PH_CNT) begin
      phase = cqrd_pkg::PH_EXT;
    end else begin
      phase  = cqrd_pkg::PH_B0;
      rep_ok = 1'b0;
      got    = place_run(cur_quad, EXT_COUNT_BASE + value, 1'b1, r);
    end
    if (got) runs_due.push_back(r);
    // End of frame: drop any partial quad or dangling count and start over.
    if (last) clear_decoder();
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_run(input run_t seen);
    run_t want;
    if (runs_due.size() == 0) begin
      report_mismatch($sformatf("descriptor with nothing expected, quad_value 0x%h",
                                seen.quad));
      return;
    end
    want = runs_due.pop_front();
    check_field("quad_value",    seen.quad,     want.quad);
    check_field("start_address", seen.addr,     want.addr);
    check_field("start_row",     seen.row,      want.row);
    check_field("start_column",  seen.col,      want.col);
    check_field("row_count",     seen.rows,     want.rows);
    check_field("is_repeat",     seen.rep,      want.rep);
    check_field("column_done",   seen.col_done, want.col_done);
    check_field("frame_done",    seen.frm_done, want.frm_done);
    check_field("overrun",       seen.ovr,      want.ovr);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: offer the next request from the backlog; hold it until the
  // decoder takes it, then predict on the byte just accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    stream_byte_t nxt;
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else begin
      if (byte_in.valid && byte_in.ready) decode_byte(byte_in.byte_value, byte_in.last_in_frame);
      if (!byte_in.valid || byte_in.ready) begin
        // Drop valid now and then to leave gaps in the stream.
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_backlog.pop_front();
          byte_in.valid         <= 1'b1;
          byte_in.byte_value    <= nxt.value;
          byte_in.last_in_frame <= nxt.last;
        end else begin
          byte_in.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Descriptor monitor: check each accepted request, then stall at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : collect_runs
    run_t seen;
    if (rst) begin
      run_out.ready <= 1'b0;
    end else begin
      if (run_out.valid && run_out.ready) begin
        seen = '{run_out.quad_value, run_out.start_address, run_out.start_row,
                 run_out.start_column, run_out.row_count, run_out.is_repeat,
                 run_out.column_done, run_out.frame_done, run_out.overrun};
        check_run(seen);
      end
      run_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Append a quad, leftmost pixel first.
  function automatic void push_quad(ref stream_byte_t s[$], input logic [31:0] q);
    for (int i = 0; i < 4; i++) s.push_back('{q[8 * i +: 8], 1'b0});
  endfunction

  // Build one frame of literals and runs with random content, a little noise,
  // and sometimes a truncated tail. An open frame carries no end mark, so
  // its state leaks into the next configuration.
  task automatic build_frame(input int runs, input bit close);
    stream_byte_t frame[$];
    logic [31:0]  q;
    int           k;
    int           n;
    int           cut;
    for (k = 0; k < runs; k++) begin
      if ($urandom_range(99) < 4) begin
        for (n = $urandom_range(1, 3); n > 0; n--) frame.push_back('{8'($urandom()), 1'b0});
      end else begin
        q = $urandom();
        push_quad(frame, q);
        if ($urandom_range(99) < 45) begin
          push_quad(frame, q);
          if ($urandom_range(3) == 0) begin
            frame.push_back('{8'd0, 1'b0});
            frame.push_back('{8'($urandom()), 1'b0});
          end else if ($urandom_range(1)) begin
            frame.push_back('{8'($urandom_range(1, 6)), 1'b0});
          end else begin
            frame.push_back('{8'($urandom_range(1, 255)), 1'b0});
          end
        end
      end
    end
    if (close) begin
      // Cut the tail now and then: partial quad or a run missing its count.
      if ($urandom_range(99) < 15 && frame.size() > 3) begin
        cut   = $urandom_range(1, 3);
        frame = frame[0 : $ - cut];
      end
      frame[frame.size() - 1].last = 1'b1;
    end
    bytes_queued += frame.size();
    foreach (frame[i]) byte_backlog.push_back(frame[i]);
  endtask

  // Wait until every request went in and every descriptor came out, then
  // give the two pipeline stages time to drain anything that closes silently.
  task automatic settle();
    do @(posedge clk);
    while (byte_backlog.size() != 0 || byte_in.valid || runs_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic idx, input logic [9:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {22'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == cqrd_pkg::REG_WIDTH) reg_width = value;
    else reg_height = value;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stream_byte_t seq[$];
    logic [9:0]   widths[PHASES];
    logic [9:0]   heights[PHASES];
    int           budget;

    // Known values on every input from time zero.
    byte_in.valid         = 1'b0;
    byte_in.byte_value    = 8'd0;
    byte_in.last_in_frame = 1'b0;
    run_out.ready         = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    bytes_queued = 0;
    mismatches   = 0;
    cycle_count  = 0;

    reg_width  = cqrd_pkg::WIDTH_RESET;
    reg_height = cqrd_pkg::HEIGHT_RESET;
    clear_decoder();

    // Geometry per phase: tiny frames, odd and sub-quad widths, height 0,
    // saturated sizes, then random small frames.
    widths  = '{10'd240, 10'd4, 10'd1023, 10'd6, 10'd2, 10'd512, 10'd1023, 10'd8,
                10'd0, 10'd0, 10'd0, 10'd0};
    heights = '{10'd160, 10'd1, 10'd0, 10'd3, 10'd5, 10'd512, 10'd1023, 10'd600,
                10'd0, 10'd0, 10'd0, 10'd0};

    // Sender gaps rare, receiver stalls heavy.
    send_idle_pct  = 8;
    recv_stall_pct = 71;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed frame at reset geometry:
    //   all-ones literal, then its run with an extended count of 511, which
    //   overruns the column; all-zeros literal with a run of one; the same
    //   quad again, now a literal since a run just ended; a two-byte partial
    //   quad closing the frame.
    push_quad(seq, 32'hFFFF_FFFF);
    push_quad(seq, 32'hFFFF_FFFF);
    seq.push_back('{8'h00, 1'b0});
    seq.push_back('{8'hFF, 1'b0});
    push_quad(seq, 32'h0000_0000);
    push_quad(seq, 32'h0000_0000);
    seq.push_back('{8'h01, 1'b0});
    push_quad(seq, 32'h0000_0000);
    seq.push_back('{8'h5A, 1'b0});
    seq.push_back('{8'hA5, 1'b1});
    bytes_queued += seq.size();
    foreach (seq[i]) byte_backlog.push_back(seq[i]);

    for (int p = 1; p < PHASES; p++) begin
      settle();
      // Swap the idling sides, then run with no idling at all.
      if (p == 4) begin
        send_idle_pct  = 71;
        recv_stall_pct = 8;
      end else if (p == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (p >= 8) begin
        widths[p]  = 10'($urandom_range(4, 48));
        heights[p] = 10'($urandom_range(1, 20));
      end
      write_register(cqrd_pkg::REG_WIDTH, widths[p]);
      write_register(cqrd_pkg::REG_HEIGHT, heights[p]);

      // Running total target, so overshoot in one phase shortens the next.
      budget = p * RANDOM_BYTES / (PHASES - 1);
      while (bytes_queued < budget) build_frame($urandom_range(1, 24), 1'b1);
      // Leave a frame open half the time so the next geometry lands mid-frame.
      if ($urandom_range(1)) build_frame($urandom_range(1, 6), 1'b0);
    end

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
